// ===== src/crc_checked_frame_deframer_assert.svh =====
// Assertion macros used by the deframer port checker.
`ifndef CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define CCFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define CCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ccfd_pkg.sv =====
// Shared types, codes and the CRC byte update for the frame deframer.
package ccfd_pkg;

  // Result status codes
  localparam logic [1:0] ST_NEED   = 2'd0;
  localparam logic [1:0] ST_RESYNC = 2'd1;
  localparam logic [1:0] ST_READY  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SOF_FIRST  = 3'd0;
  localparam logic [2:0] CFG_SOF_SECOND = 3'd1;
  localparam logic [2:0] CFG_LIMIT      = 3'd2;
  localparam logic [2:0] CFG_POLY       = 3'd3;
  localparam logic [2:0] CFG_START      = 3'd4;
  localparam logic [2:0] CFG_REFLECT    = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OUT_NEED    = 2'd0,
    OUT_RESYNC  = 2'd1,
    OUT_EMPTY   = 2'd2,
    OUT_PAYLOAD = 2'd3
  } out_kind_t;

  typedef struct packed {
    logic      ld_type;
    logic      crc_init;
    logic      crc_upd;
    logic      ld_len_lo;
    logic      clr_fill;
    logic      wr_payload;
    logic      ld_crc_lo;
    logic      rd_start;
    logic      rd_issue;
    logic      rd_adv;
    logic      emit;
    out_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic crc_ok;
    logic rd_last;
    logic out_free;
  } dp_sts_t;

  // One byte through a 16-bit CRC, either bit order.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly, input logic refl);
    logic [15:0] c;
    c = refl ? (crc ^ {8'h00, b}) : (crc ^ {b, 8'h00});
    for (int i = 0; i < 8; i++) begin
      if (refl) begin
        c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end else begin
        c = c[15] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

// ===== src/ccfd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ccfd_ctrl.sv =====
// Frame phase controller: hunts markers, sequences header, payload, CRC and readout.
module ccfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ccfd_pkg::dp_sts_t sts,
  output ccfd_pkg::dp_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_SOF0  = 10'b00_0000_0001,
    S_SOF1  = 10'b00_0000_0010,
    S_TYPE  = 10'b00_0000_0100,
    S_LENLO = 10'b00_0000_1000,
    S_LENHI = 10'b00_0001_0000,
    S_DATA  = 10'b00_0010_0000,
    S_CRCLO = 10'b00_0100_0000,
    S_CRCHI = 10'b00_1000_0000,
    S_READ  = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_state;
  logic   acc;

  assign in_state = (state_r != S_READ) && (state_r != S_EMIT);
  assign in_ready = in_state && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.kind  = ccfd_pkg::OUT_NEED;
    case (state_r)
      S_SOF0: begin
        if (acc) begin
          cmd.emit = 1'b1;
          if (sts.is_first) state_nxt = S_SOF1;
        end
      end
      S_SOF1: begin
        if (acc) begin
          cmd.emit = 1'b1;
          if (sts.is_second) state_nxt = S_TYPE;
          else if (!sts.is_first) state_nxt = S_SOF0;
        end
      end
      S_TYPE: begin
        if (acc) begin
          cmd.emit     = 1'b1;
          cmd.ld_type  = 1'b1;
          cmd.crc_init = 1'b1;
          state_nxt    = S_LENLO;
        end
      end
      S_LENLO: begin
        if (acc) begin
          cmd.emit      = 1'b1;
          cmd.ld_len_lo = 1'b1;
          cmd.crc_upd   = 1'b1;
          state_nxt     = S_LENHI;
        end
      end
      S_LENHI: begin
        if (acc) begin
          cmd.emit    = 1'b1;
          cmd.crc_upd = 1'b1;
          if (sts.len_over) begin
            cmd.kind  = ccfd_pkg::OUT_RESYNC;
            state_nxt = S_SOF0;
          end else begin
            cmd.clr_fill = 1'b1;
            state_nxt    = sts.len_zero ? S_CRCLO : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.emit       = 1'b1;
          cmd.wr_payload = 1'b1;
          cmd.crc_upd    = 1'b1;
          if (sts.data_done) state_nxt = S_CRCLO;
        end
      end
      S_CRCLO: begin
        if (acc) begin
          cmd.emit      = 1'b1;
          cmd.ld_crc_lo = 1'b1;
          state_nxt     = S_CRCHI;
        end
      end
      S_CRCHI: begin
        if (acc) begin
          if (!sts.crc_ok) begin
            cmd.emit  = 1'b1;
            cmd.kind  = ccfd_pkg::OUT_RESYNC;
            state_nxt = S_SOF0;
          end else if (sts.len_zero) begin
            cmd.emit  = 1'b1;
            cmd.kind  = ccfd_pkg::OUT_EMPTY;
            state_nxt = S_SOF0;
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        // RAM data is valid here; hold it until the output slot frees up
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = ccfd_pkg::OUT_PAYLOAD;
          cmd.rd_adv = 1'b1;
          state_nxt  = sts.rd_last ? S_SOF0 : S_READ;
        end
      end
      default: state_nxt = S_SOF0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SOF0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/ccfd_datapath.sv =====
// Deframer datapath: config registers, header fields, CRC, payload store, output register.
module ccfd_datapath #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ccfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccfd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                          in_data,
  input  ccfd_pkg::dp_cmd_t                   cmd,
  output ccfd_pkg::dp_sts_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [7:0]                          out_frame_type,
  output logic [6:0]                          out_frame_length,
  output logic [5:0]                          out_byte_index,
  output logic [7:0]                          out_payload_byte,
  output logic                                out_byte_valid,
  output logic                                out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [6:0] MaxLim = 7'(MAX_PAYLOAD);

  // configuration
  logic [7:0]  sof_first_r, sof_second_r;
  logic [6:0]  limit_r;
  logic [15:0] poly_r, start_r;
  logic        refl_r;

  // frame state
  logic [7:0]  type_r;
  logic [7:0]  len_r;
  logic [6:0]  fill_r, fill_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r;
  logic [5:0]  rd_cnt_r, rd_cnt_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_status_r;
  logic [7:0]  o_type_r;
  logic [6:0]  o_len_r;
  logic [5:0]  o_idx_r;
  logic [7:0]  o_byte_r;
  logic        o_bvalid_r;
  logic        o_last_r;

  logic [6:0]  lim;
  logic [6:0]  fill_inc;
  logic [6:0]  rd_inc;
  logic [7:0]  ram_rdata;

  assign lim      = (limit_r > MaxLim) ? MaxLim : limit_r;
  assign fill_inc = fill_r + 7'd1;
  assign rd_inc   = {1'b0, rd_cnt_r} + 7'd1;

  assign sts.is_first  = (in_data == sof_first_r);
  assign sts.is_second = (in_data == sof_second_r);
  // full 16-bit length {in_data, len_r} against the limit
  assign sts.len_over  = (in_data != 8'd0) || (len_r > {1'b0, lim});
  assign sts.len_zero  = (len_r == 8'd0);
  assign sts.data_done = ({1'b0, fill_inc} >= len_r) || (fill_inc >= MaxLim);
  assign sts.crc_ok    = ({in_data, crc_lo_r} == crc_r);
  assign sts.rd_last   = ({1'b0, rd_inc} == len_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    crc_nxt = crc_r;
    if (cmd.crc_init) begin
      crc_nxt = ccfd_pkg::crc_byte(start_r, in_data, poly_r, refl_r);
    end else if (cmd.crc_upd) begin
      crc_nxt = ccfd_pkg::crc_byte(crc_r, in_data, poly_r, refl_r);
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.clr_fill) fill_nxt = 7'd0;
    else if (cmd.wr_payload) fill_nxt = fill_inc;
  end

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (cmd.rd_start) rd_cnt_nxt = 6'd0;
    else if (cmd.rd_adv) rd_cnt_nxt = rd_inc[5:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_first_r  <= 8'd170;
      sof_second_r <= 8'd85;
      limit_r      <= 7'd64;
      poly_r       <= 16'h1021;
      start_r      <= 16'hFFFF;
      refl_r       <= 1'b0;
      fill_r       <= 7'd0;
      rd_cnt_r     <= 6'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ccfd_pkg::CFG_SOF_FIRST:  sof_first_r  <= cfg_data[7:0];
          ccfd_pkg::CFG_SOF_SECOND: sof_second_r <= cfg_data[7:0];
          ccfd_pkg::CFG_LIMIT:      limit_r      <= cfg_data[6:0];
          ccfd_pkg::CFG_POLY:       poly_r       <= cfg_data;
          ccfd_pkg::CFG_START:      start_r      <= cfg_data;
          ccfd_pkg::CFG_REFLECT:    refl_r       <= cfg_data[0];
          default: ;
        endcase
      end
      fill_r      <= fill_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (cmd.ld_type) type_r <= in_data;
    if (cmd.ld_len_lo) len_r <= in_data;
    if (cmd.ld_crc_lo) crc_lo_r <= in_data;
    if (cmd.emit) begin
      case (cmd.kind)
        ccfd_pkg::OUT_NEED, ccfd_pkg::OUT_RESYNC: begin
          o_status_r <= (cmd.kind == ccfd_pkg::OUT_RESYNC) ? ccfd_pkg::ST_RESYNC
                                                            : ccfd_pkg::ST_NEED;
          o_type_r   <= 8'd0;
          o_len_r    <= 7'd0;
          o_idx_r    <= 6'd0;
          o_byte_r   <= 8'd0;
          o_bvalid_r <= 1'b0;
          o_last_r   <= 1'b1;
        end
        ccfd_pkg::OUT_EMPTY: begin
          o_status_r <= ccfd_pkg::ST_READY;
          o_type_r   <= type_r;
          o_len_r    <= 7'd0;
          o_idx_r    <= 6'd0;
          o_byte_r   <= 8'd0;
          o_bvalid_r <= 1'b0;
          o_last_r   <= 1'b1;
        end
        default: begin
          o_status_r <= ccfd_pkg::ST_READY;
          o_type_r   <= type_r;
          o_len_r    <= len_r[6:0];
          o_idx_r    <= rd_cnt_r;
          o_byte_r   <= ram_rdata;
          o_bvalid_r <= 1'b1;
          o_last_r   <= sts.rd_last;
        end
      endcase
    end
  end

  ccfd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_payload),
    .waddr(fill_r[AW-1:0]),
    .wdata(in_data),
    .re   (cmd.rd_issue),
    .raddr(rd_cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_frame_type   = o_type_r;
  assign out_frame_length = o_len_r;
  assign out_byte_index   = o_idx_r;
  assign out_payload_byte = o_byte_r;
  assign out_byte_valid   = o_bvalid_r;
  assign out_last         = o_last_r;

endmodule

// ===== src/crc_checked_frame_deframer.sv =====
// Deframer top level: byte stream in, one result per byte or a payload burst per good frame.
// Each accepted byte, bar the final CRC byte of a good non-empty frame, is answered by a status
// result from the output register on the next cycle; bytes flow one per cycle unless out stalls.
// A good frame's payload then streams from the store byte by byte (registered RAM read, then
// output load); no input is taken while it streams.
// rst_n (synchronous) restores config defaults, returns to marker hunt and empties the
// output; the payload store is not cleared.
module crc_checked_frame_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ccfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] frame_type, [14:8] frame_length, [20:15] byte_index, [28:21] payload_byte, 0 pad
  output logic [31:0]                     out_tdata,
  output logic [2:0]                      out_tuser,  // [1:0] status, [2] byte_valid
  output logic                            out_tlast   // last
);

  ccfd_pkg::dp_cmd_t cmd;
  ccfd_pkg::dp_sts_t sts;

  logic [1:0] status;
  logic [7:0] frame_type;
  logic [6:0] frame_length;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       byte_valid;

  ccfd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  ccfd_datapath #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_data         (in_tdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (status),
    .out_frame_type  (frame_type),
    .out_frame_length(frame_length),
    .out_byte_index  (byte_index),
    .out_payload_byte(payload_byte),
    .out_byte_valid  (byte_valid),
    .out_last        (out_tlast)
  );

  assign out_tdata = {3'b000, payload_byte, byte_index, frame_length, frame_type};
  assign out_tuser = {byte_valid, status};

endmodule

// ===== src/ccfd_checker.sv =====
// Port-level checker for the frame deframer, bound to the top level.
`include "crc_checked_frame_deframer_assert.svh"

module ccfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  `CCFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  `CCFD_ASSERT_NOW(a_status_only, out_tvalid && (out_tuser[1:0] != ccfd_pkg::ST_READY), out_tlast && !out_tuser[2] && (out_tdata == 32'd0), "status result carries data")
  `CCFD_ASSERT_NOW(a_index_range, out_tvalid && out_tuser[2], (out_tuser[1:0] == ccfd_pkg::ST_READY) && ({1'b0, out_tdata[20:15]} < out_tdata[14:8]), "payload index out of frame")
  `CCFD_ASSERT_NOW(a_last_index, out_tvalid && out_tuser[2], out_tlast == (({1'b0, out_tdata[20:15]} + 7'd1) == out_tdata[14:8]), "last flag misplaced in burst")
  `CCFD_ASSERT_NOW(a_burst_block, out_tvalid && out_tuser[2] && !out_tlast, !in_tready, "input request taken mid burst")

endmodule

bind crc_checked_frame_deframer ccfd_checker u_ccfd_checker (.*);
